@@ sv/assert_macros.svh @@
// assertion macros used by the table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define KOLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KOLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/kolt_pkg.sv @@
// shared types and constants for the keyed ordered list table
package kolt_pkg;

	localparam int ENTRIES = 64;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CMP_W   = (CNT_W > 8) ? CNT_W : 8;
	localparam int KEY_W   = 16;
	localparam int HDL_W   = 32;
	localparam int POS_W   = 8;
	localparam int OUTC_W  = 7;

	typedef logic [2:0] op_t;

	localparam op_t OP_INS_FRONT  = 3'd0;
	localparam op_t OP_INS_BACK   = 3'd1;
	localparam op_t OP_INS_SORTED = 3'd2;
	localparam op_t OP_RM_FRONT   = 3'd3;
	localparam op_t OP_RM_BACK    = 3'd4;
	localparam op_t OP_RM_KEY     = 3'd5;
	localparam op_t OP_FIND_POS   = 3'd6;
	localparam op_t OP_FIND_KEY   = 3'd7;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_MISS   = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] handle;
	} rec_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic             exec;
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] handle;
		logic [POS_W-1:0] position;
	} cmd_t;

	// per-cell position flags derived from the entry count and the requested position
	typedef struct packed {
		logic occ;
		logic at_tail;
		logic pos_hit;
	} cell_ctl_t;

endpackage

@@ sv/kolt_cell.sv @@
// one list cell: holds a record and shifts to or from its neighbors
module kolt_cell (
	input  logic                        clk,
	input  kolt_pkg::cmd_t              cmd,
	input  kolt_pkg::cell_ctl_t         ctl,
	input  kolt_pkg::rec_t              left,
	input  kolt_pkg::rec_t              right,
	input  logic                        seen_in,
	output logic                        seen_out,
	output kolt_pkg::rec_t              rec,
	output logic [kolt_pkg::HDL_W-1:0]  sel_handle
);
	import kolt_pkg::*;

	rec_t rec_q;
	rec_t rec_d;
	rec_t new_rec;
	logic hit;
	logic first;
	logic sel;

	assign new_rec.key    = cmd.key;
	assign new_rec.handle = cmd.handle;

	// sorted insert looks for the first key not smaller, the rest for equality
	assign hit      = ctl.occ && ((cmd.op == OP_INS_SORTED) ? (rec_q.key >= cmd.key)
	                                                         : (rec_q.key == cmd.key));
	assign seen_out = seen_in | hit;
	assign first    = hit & ~seen_in;

	always_comb begin
		rec_d = rec_q;
		unique case (cmd.op)
			OP_INS_FRONT: begin
				rec_d = left;
			end
			OP_INS_BACK: begin
				if (ctl.at_tail) begin
					rec_d = new_rec;
				end
			end
			OP_INS_SORTED: begin
				if (first || (ctl.at_tail && !seen_in)) begin
					rec_d = new_rec;
				end else if (seen_in) begin
					rec_d = left;
				end
			end
			OP_RM_FRONT: begin
				rec_d = right;
			end
			OP_RM_KEY: begin
				if (seen_out) begin
					rec_d = right;
				end
			end
			default: begin
				rec_d = rec_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rec_q <= rec_d;
		end
	end

	assign sel        = ((cmd.op == OP_FIND_KEY) && first) ||
	                    ((cmd.op == OP_FIND_POS) && ctl.pos_hit);
	assign sel_handle = sel ? rec_q.handle : '0;
	assign rec        = rec_q;

endmodule

@@ sv/kolt_chain.sv @@
// row of list cells with neighbor wiring and handle gather
module kolt_chain (
	input  logic                        clk,
	input  kolt_pkg::cmd_t              cmd,
	input  logic [kolt_pkg::CNT_W-1:0]  count,
	output logic                        any_hit,
	output logic [kolt_pkg::HDL_W-1:0]  found_handle
);
	import kolt_pkg::*;

	rec_t             recs   [ENTRIES];
	logic [HDL_W-1:0] sels   [ENTRIES];
	logic [ENTRIES:0] seen;
	rec_t             new_rec;

	assign new_rec.key    = cmd.key;
	assign new_rec.handle = cmd.handle;
	assign seen[0]        = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;
		rec_t      left;
		rec_t      right;

		assign ctl.occ     = CNT_W'(i) < count;
		assign ctl.at_tail = CNT_W'(i) == count;
		assign ctl.pos_hit = ctl.occ && (CMP_W'(cmd.position) == CMP_W'(i + 1));

		if (i == 0) begin : g_head
			assign left = new_rec;
		end else begin : g_mid
			assign left = recs[i-1];
		end

		if (i == ENTRIES - 1) begin : g_tail
			assign right = recs[i];
		end else begin : g_body
			assign right = recs[i+1];
		end

		kolt_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.ctl        (ctl),
			.left       (left),
			.right      (right),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.rec        (recs[i]),
			.sel_handle (sels[i])
		);
	end

	assign any_hit = seen[ENTRIES];

	// at most one cell selects, so an or over all cells gives its handle
	always_comb begin
		found_handle = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			found_handle = found_handle | sels[j];
		end
	end

endmodule

@@ sv/keyed_ordered_list_table.sv @@
// keyed ordered list table top level: handshakes, entry count and result register
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------------------
// in      | into      | in_valid / in_ready  | op, key, item_handle, position
// out     | out of    | out_valid / out_ready| status, found_handle, entry_count, is_empty
//
// an operation is taken in one cycle and executed in the next, where the whole row of
// cells compares against the key and, for front or sorted inserts and front or key
// removals, shifts its records by one place; the result is registered from the execute
// cycle, and a new item is taken in the cycle its predecessor's result is transferred,
// so the table takes no new item before the last one's result is transferred
// reset clears only the entry count and the handshake state; cell contents need no reset
// a stalled result holds the table still: no new item is taken until it is transferred
module keyed_ordered_list_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kolt_pkg::op_t                 op,
	input  logic [kolt_pkg::KEY_W-1:0]    key,
	input  logic [kolt_pkg::HDL_W-1:0]    item_handle,
	input  logic [kolt_pkg::POS_W-1:0]    position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kolt_pkg::status_t             status,
	output logic [kolt_pkg::HDL_W-1:0]    found_handle,
	output logic [kolt_pkg::OUTC_W-1:0]   entry_count,
	output logic                          is_empty
);
	import kolt_pkg::*;

	// accepted operation, held through its execute cycle
	op_t              op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [HDL_W-1:0] handle_s1;
	logic [POS_W-1:0] position_s1;
	logic             busy_q;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [HDL_W-1:0] found_q;

	cmd_t             cmd;
	logic             any_hit;
	logic [HDL_W-1:0] chain_found;
	logic             full;
	logic             empty;
	logic             bad_pos;
	logic             allowed;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;

	// take a new item when not executing and once the previous result is gone or leaving now
	assign in_ready = !busy_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= op;
			key_s1      <= key;
			handle_s1   <= item_handle;
			position_s1 <= position;
		end
	end

	assign full    = count_q == CNT_W'(ENTRIES);
	assign empty   = count_q == '0;
	assign bad_pos = (position_s1 == '0) || (CMP_W'(position_s1) > CMP_W'(count_q));

	// cells only move when the operation may change the table
	always_comb begin
		unique case (op_s1)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: allowed = !full;
			OP_RM_FRONT, OP_RM_BACK:                  allowed = !empty;
			default:                                  allowed = 1'b1;
		endcase
	end

	assign cmd.exec     = busy_q && allowed;
	assign cmd.op       = op_s1;
	assign cmd.key      = key_s1;
	assign cmd.handle   = handle_s1;
	assign cmd.position = position_s1;

	kolt_chain u_chain (
		.clk          (clk),
		.cmd          (cmd),
		.count        (count_q),
		.any_hit      (any_hit),
		.found_handle (chain_found)
	);

	// status and next count of the executing operation
	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		unique case (op_s1)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_RM_FRONT, OP_RM_BACK: begin
				if (empty) begin
					status_d = ST_MISS;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_RM_KEY: begin
				if (any_hit) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_MISS;
				end
			end
			OP_FIND_POS: begin
				if (bad_pos) begin
					status_d = ST_BADPOS;
				end
			end
			default: begin
				if (!any_hit) begin
					status_d = ST_MISS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the cell row only selects a handle on a successful find
	always_ff @(posedge clk) begin
		if (busy_q) begin
			status_q <= status_d;
			found_q  <= chain_found;
		end
	end

	// the count only moves in an execute cycle, which follows the input transfer
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_q;
	assign entry_count  = OUTC_W'(count_q);
	assign is_empty     = empty;

	`include "assert_macros.svh"

	`KOLT_ASSERT_NEXT(a_exec_gives_result, busy_q, out_valid_q, "execute cycle gave no result")
	`KOLT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(ENTRIES), "entry count above capacity")
	`KOLT_ASSERT_NEXT(a_count_holds, out_valid_q && !out_ready, $stable(count_q),
		"count moved under a stalled result")
	`KOLT_ASSERT_NEXT(a_full_reject,
		busy_q && full && (op_s1 == OP_INS_FRONT || op_s1 == OP_INS_BACK ||
		op_s1 == OP_INS_SORTED), status_q == ST_FULL, "insert into full table not rejected")

endmodule
